>>> sv/assert_macros.svh
// Assertion macros shared by the interpolator RTL.
// No dependencies; included by the files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/bci_pkg.sv
// Shared constants and codes for the breakpoint curve interpolator.
// No dependencies; imported by bci_div and the top level.
`default_nettype none

package bci_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int VALUE_BITS_DEF = 16;

    localparam int RPM_W     = 16;   // rpm field
    localparam int CNT_W     = 5;    // points_in_use register
    localparam int IDX_W     = 4;    // point_index field
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_POINTS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK = 1'b1;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

endpackage

`default_nettype wire

>>> sv/bci_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on bci_pkg; the quotient must be known to fit VALUE_BITS bits.
`default_nettype none

module bci_div #(
    parameter int VALUE_BITS = bci_pkg::VALUE_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    input  wire logic [bci_pkg::RPM_W+VALUE_BITS-1:0]  i_dividend,
    input  wire logic [bci_pkg::RPM_W-1:0]             i_divisor,
    output logic                                       o_done,
    output logic [VALUE_BITS-1:0]                      o_quot
);
    import bci_pkg::*;

    localparam int CW = $clog2(VALUE_BITS);

    logic [RPM_W-1:0]      r_rem;
    logic [VALUE_BITS-1:0] r_dvd;
    logic [RPM_W-1:0]      r_div;
    logic [CW-1:0]         r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [RPM_W:0]        trial;
    logic [RPM_W:0]        diff;
    logic                  q_bit;

    // dividend top half is below the divisor, so the remainder stays in RPM_W bits
    assign trial = {r_rem, r_dvd[VALUE_BITS-1]};
    assign diff  = trial - {1'b0, r_div};
    assign q_bit = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(VALUE_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            {r_rem, r_dvd} <= i_dividend;
            r_div          <= i_divisor;
        end else if (r_busy) begin
            r_rem <= q_bit ? diff[RPM_W-1:0] : trial[RPM_W-1:0];
            r_dvd <= {r_dvd[VALUE_BITS-2:0], q_bit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;

endmodule

`default_nettype wire

>>> sv/breakpoint_curve_interpolator_top.sv
// Breakpoint curve interpolator: breakpoint table, segment search and interpolation.
// Depends on bci_pkg, bci_div and assert_macros.svh.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_kind i_point_index i_rpm i_point_value
//  out     | output    | o_out_valid / i_out_ready  | o_sample_value o_used_fallback
//  cfg     | input     | i_cfg_we (no wait)         | i_cfg_idx i_cfg_data
//
// A breakpoint write is one transfer and finishes at its accepting edge.
// A sample raises o_out_valid through the fallback path on an empty table,
// after a read of the first and, if needed, the last point when clamped to one of them,
// and after the table walk up to segment k (1..n-1) and the serial divider when
// interpolated; the walk does one memory read per cycle. Input is ready again
// at the edge that raises o_out_valid.
// Reset (synchronous, active low) clears the control state and both registers;
// the table is not cleared. A stalled output holds its transfer while the next
// item is already accepted; only the following result waits for it.
`default_nettype none
`include "assert_macros.svh"

module breakpoint_curve_interpolator_top #(
    parameter int MAX_POINTS = bci_pkg::MAX_POINTS_DEF,
    parameter int VALUE_BITS = bci_pkg::VALUE_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration
    input  wire logic                                i_cfg_we,
    input  wire logic [bci_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [VALUE_BITS-1:0]               i_cfg_data,
    // input items
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic                                i_kind,
    input  wire logic [bci_pkg::IDX_W-1:0]           i_point_index,
    input  wire logic [bci_pkg::RPM_W-1:0]           i_rpm,
    input  wire logic signed [VALUE_BITS-1:0]        i_point_value,
    // results
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic signed [VALUE_BITS-1:0]             o_sample_value,
    output logic                                     o_used_fallback
);
    import bci_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int IW = $clog2(MAX_POINTS + 1);
    localparam int EW = RPM_W + VALUE_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIRST = 3'd1;   // entry 0 on the read port
    localparam logic [2:0] S_LAST  = 3'd2;   // last entry on the read port
    localparam logic [2:0] S_SCAN  = 3'd3;   // walking segments upward
    localparam logic [2:0] S_MUL   = 3'd4;   // product into divider
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;   // result waits for output register

    // configuration registers
    logic [CNT_W-1:0]              r_points;
    logic signed [VALUE_BITS-1:0]  r_fallback;

    // control
    logic [2:0]                    r_state;
    logic [2:0]                    n_state;
    logic [IW-1:0]                 r_idx;
    logic                          r_o_valid;

    // payload
    logic [RPM_W-1:0]              r_q;
    logic [RPM_W-1:0]              r_prev_rpm;
    logic signed [VALUE_BITS-1:0]  r_prev_val;
    logic [RPM_W-1:0]              r_off;
    logic [VALUE_BITS-1:0]         r_dvmag;
    logic                          r_neg;
    logic [RPM_W-1:0]              r_span;
    logic signed [VALUE_BITS-1:0]  r_base;
    logic signed [VALUE_BITS-1:0]  r_res_val;
    logic                          r_res_fb;
    logic signed [VALUE_BITS-1:0]  r_o_val;
    logic                          r_o_fb;

    // table memory: {rpm, value} per breakpoint
    logic [EW-1:0]                 mem [MAX_POINTS];
    logic [EW-1:0]                 r_rd_data;
    logic [AW-1:0]                 rd_addr;
    logic [AW-1:0]                 wr_addr;
    logic                          wr_en;

    logic                          in_fire;
    logic                          out_load;
    logic [IW-1:0]                 cnt_eff;
    logic [IW-1:0]                 last_idx;
    logic [IW-1:0]                 idx_nxt;
    logic [RPM_W-1:0]              rd_rpm;
    logic signed [VALUE_BITS-1:0]  rd_val;
    logic                          seg_hit;
    logic signed [VALUE_BITS:0]    dv;
    logic [VALUE_BITS:0]           dv_abs;
    logic signed [VALUE_BITS:0]    quot_ext;
    logic signed [VALUE_BITS:0]    res_sum;
    logic                          div_start;
    logic                          div_done;
    logic [VALUE_BITS-1:0]         div_quot;
    logic [EW-1:0]                 product;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_load = (r_state == S_DONE) && (!r_o_valid || i_out_ready);

    // count above the table depth saturates
    assign cnt_eff  = (32'(r_points) > MAX_POINTS) ? IW'(MAX_POINTS) : IW'(r_points);
    assign last_idx = cnt_eff - 1'b1;
    assign idx_nxt  = r_idx + 1'b1;

    assign rd_rpm = r_rd_data[EW-1:VALUE_BITS];
    assign rd_val = r_rd_data[VALUE_BITS-1:0];

    assign wr_en   = in_fire && (i_kind == KIND_WRITE) && (32'(i_point_index) < MAX_POINTS);
    assign wr_addr = AW'(32'(i_point_index));

    always_comb begin
        case (r_state)
            S_FIRST: rd_addr = last_idx[AW-1:0];
            S_LAST:  rd_addr = AW'(1);
            S_SCAN:  rd_addr = idx_nxt[AW-1:0];
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= {i_rpm, i_point_value};
        end
        r_rd_data <= mem[rd_addr];
    end

    // segment ends at the first entry at or above the query, or at the last point in use
    assign seg_hit  = (r_q <= rd_rpm) || (r_idx == last_idx);
    assign dv       = {rd_val[VALUE_BITS-1], rd_val} - {r_prev_val[VALUE_BITS-1], r_prev_val};
    assign dv_abs   = dv[VALUE_BITS] ? (~dv + 1'b1) : dv;
    assign product  = EW'(r_off * r_dvmag);
    assign quot_ext = {1'b0, div_quot};
    assign res_sum  = r_neg ? ({r_base[VALUE_BITS-1], r_base} - quot_ext)
                            : ({r_base[VALUE_BITS-1], r_base} + quot_ext);
    assign div_start = (r_state == S_MUL);

    bci_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (product),
        .i_divisor  (r_span),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire && (i_kind == KIND_SAMPLE)) begin
                    n_state = (cnt_eff == '0) ? S_DONE : S_FIRST;
                end
            end
            S_FIRST: begin
                n_state = (r_q <= rd_rpm) ? S_DONE : S_LAST;
            end
            S_LAST: begin
                n_state = (r_q >= rd_rpm) ? S_DONE : S_SCAN;
            end
            S_SCAN: begin
                if (seg_hit) begin
                    n_state = (rd_rpm <= r_prev_rpm) ? S_DONE : S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_o_valid  <= 1'b0;
            r_points   <= '0;
            r_fallback <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POINTS:   r_points   <= i_cfg_data[CNT_W-1:0];
                    CFG_FALLBACK: r_fallback <= i_cfg_data;
                    default:      r_points   <= r_points;
                endcase
            end
            if (r_state == S_LAST) begin
                r_idx <= IW'(1);
            end else if ((r_state == S_SCAN) && !seg_hit) begin
                r_idx <= idx_nxt;
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_q       <= i_rpm;
                r_res_val <= r_fallback;
                r_res_fb  <= 1'b1;
            end
            S_FIRST: begin
                r_res_fb   <= 1'b0;
                r_res_val  <= rd_val;
                r_prev_rpm <= rd_rpm;
                r_prev_val <= rd_val;
            end
            S_LAST: begin
                r_res_val <= rd_val;
            end
            S_SCAN: begin
                r_res_val <= rd_val;
                if (!seg_hit) begin
                    r_prev_rpm <= rd_rpm;
                    r_prev_val <= rd_val;
                end
                r_off   <= r_q - r_prev_rpm;
                r_span  <= rd_rpm - r_prev_rpm;
                r_neg   <= dv[VALUE_BITS];
                r_dvmag <= dv_abs[VALUE_BITS-1:0];
                r_base  <= r_prev_val;
            end
            S_DIV: begin
                if (div_done) begin
                    r_res_val <= res_sum[VALUE_BITS-1:0];
                end
            end
            default: begin
                r_res_val <= r_res_val;
            end
        endcase
        if (out_load) begin
            r_o_val <= r_res_val;
            r_o_fb  <= r_res_fb;
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_o_valid;
    assign o_sample_value  = r_o_val;
    assign o_used_fallback = r_o_fb;

    `ASSERT_NEXT(a_empty_goes_done, i_clk, i_rst_n,
        in_fire && (i_kind == KIND_SAMPLE) && (cnt_eff == '0),
        (r_state == S_DONE) && r_res_fb, "empty-table sample did not take the fallback path")
    `ASSERT_IMPL(a_fallback_value, i_clk, i_rst_n,
        r_o_valid && r_o_fb, o_sample_value == r_fallback,
        "fallback result differs from fallback register")
    `ASSERT_IMPL(a_scan_in_range, i_clk, i_rst_n,
        r_state == S_SCAN, (r_idx != '0) && (r_idx <= last_idx),
        "segment walk left the points in use")
    `ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n,
        out_load, o_out_valid && (r_state == S_IDLE),
        "finished result not moved into the output register")

endmodule

`default_nettype wire
